// ----- src/cst_pkg.sv -----
// Shared types and codes for the control state tracker.
package cst_pkg;

  // Command codes on in_cmd; codes above CMD_QUERY act as query
  localparam logic [2:0] CMD_PRESS       = 3'd0;
  localparam logic [2:0] CMD_RELEASE     = 3'd1;
  localparam logic [2:0] CMD_SET_LATCH   = 3'd2;
  localparam logic [2:0] CMD_RELEASE_ALL = 3'd3;
  localparam logic [2:0] CMD_QUERY       = 3'd4;

  // Control kinds; the reserved kind code behaves as select
  localparam logic [1:0] KIND_MOMENTARY = 2'd0;
  localparam logic [1:0] KIND_LATCH     = 2'd1;
  localparam logic [1:0] KIND_SELECT    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KIND       = 1'b0;
  localparam logic CFG_NUM_STATES = 1'b1;

  // Reset values of the configuration registers
  localparam logic [1:0] KIND_RESET       = KIND_MOMENTARY;
  localparam logic [3:0] NUM_STATES_RESET = 4'd2;

  // Saturation limit of a hold count
  localparam logic [7:0] HOLD_MAX = 8'd255;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } cst_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the input word
    logic exec;      // apply the command, clear the scan
    logic scan_step; // compare one state and advance
    logic load_res;  // register the resolved state
  } cst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_select; // control resolves by scanning states
    logic scan_done; // every live state has been compared
  } cst_sts_t;

endpackage

// ----- src/cst_ctrl.sv -----
// Controller state machine of the control state tracker.
module cst_ctrl import cst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cst_sts_t sts,
  output cst_cmd_t ctl,
  output logic     busy,
  output logic     out_valid
);

  cst_state_t state_r, state_nxt;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through execute, scan and result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.is_select || sts.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drive datapath commands and port strobes
  always_comb begin
    ctl       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
      end
      S_SCAN: begin
        if (!sts.is_select || sts.scan_done) begin
          ctl.load_res = 1'b1;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // An accepted word always starts execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_EXEC)
    else $error("accepted word did not start execution");

  // The result strobe lasts one cycle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result follows only a finished scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_SCAN))
    else $error("result without a preceding scan");

  // A loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_res |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ----- src/cst_dp.sv -----
// Datapath of the control state tracker: config, hold counts, stamps, scan.
module cst_dp import cst_pkg::*; #(
  parameter int MAX_STATES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_cmd,
  input  logic signed [3:0] in_state_index,
  input  logic              in_latch_on,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  input  cst_cmd_t          ctl,
  output cst_sts_t          sts,
  output logic [2:0]        out_current_state
);

  localparam int IW = $clog2(MAX_STATES);

  logic [1:0]  kind_r;
  logic [3:0]  num_states_r;
  logic [2:0]  cmd_r;
  logic [3:0]  idx_r;
  logic        latch_on_r;
  logic [7:0]  hold_r [MAX_STATES];
  logic [31:0] stamp_r [MAX_STATES];
  logic [31:0] order_r;
  logic        latched_r;
  logic [3:0]  sc_r;
  logic [IW-1:0] best_r;
  logic [31:0] best_stamp_r;
  logic [2:0]  result_r;

  logic [3:0]    live;
  logic [3:0]    st;
  logic          st_ok;
  logic [IW-1:0] addr;
  logic [7:0]    hold_rd;
  logic [31:0]   stamp_rd;
  logic          hold_we;
  logic [7:0]    hold_wd;
  logic          stamp_we;
  logic          clr_all;
  logic [31:0]   order_nxt;
  logic          latched_nxt;
  logic          hit;
  logic [3:0]    best_ext;
  logic [2:0]    result_nxt;

  // Clamp the state count to the array depth
  assign live = ({1'b0, num_states_r} > 5'(MAX_STATES)) ? 4'(MAX_STATES) : num_states_r;

  // Map a negative index to state 1 and range-check it
  assign st    = idx_r[3] ? 4'd1 : idx_r;
  assign st_ok = st < live;

  // Select one entry: the command's state while executing, else the scan slot
  assign addr     = ctl.exec ? st[IW-1:0] : sc_r[IW-1:0];
  assign hold_rd  = hold_r[addr];
  assign stamp_rd = stamp_r[addr];

  assign sts.is_select = kind_r[1];
  assign sts.scan_done = (sc_r == live);

  // Decide the command's effect on the state
  always_comb begin
    hold_we     = 1'b0;
    hold_wd     = hold_rd;
    stamp_we    = 1'b0;
    clr_all     = 1'b0;
    order_nxt   = order_r + 32'd1;
    latched_nxt = latched_r;
    case (cmd_r)
      CMD_PRESS: begin
        if (kind_r == KIND_LATCH) begin
          latched_nxt = ~latched_r;
        end else if (st_ok) begin
          hold_we  = 1'b1;
          hold_wd  = (hold_rd < HOLD_MAX) ? hold_rd + 8'd1 : hold_rd;
          stamp_we = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (kind_r != KIND_LATCH && st_ok && hold_rd != 8'd0) begin
          hold_we = 1'b1;
          hold_wd = hold_rd - 8'd1;
        end
      end
      CMD_SET_LATCH: begin
        if (kind_r == KIND_LATCH) latched_nxt = latch_on_r;
      end
      CMD_RELEASE_ALL: begin
        clr_all = 1'b1;
      end
      default: begin
        clr_all = 1'b0;
      end
    endcase
  end

  // Newest held state wins; equal stamps go to the later index
  assign hit = (hold_rd != 8'd0) && (stamp_rd >= best_stamp_r);

  // Resolve the state shown for the control kind
  assign best_ext = 4'(best_r);
  always_comb begin
    if (kind_r == KIND_LATCH) begin
      result_nxt = {2'b00, latched_r};
    end else if (kind_r == KIND_MOMENTARY) begin
      result_nxt = {2'b00, hold_r[1] != 8'd0};
    end else begin
      result_nxt = best_ext[2:0];
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= KIND_RESET;
      num_states_r <= NUM_STATES_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_KIND) begin
        kind_r <= cfg_data[1:0];
      end else begin
        num_states_r <= cfg_data;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r      <= in_cmd;
      idx_r      <= in_state_index;
      latch_on_r <= in_latch_on;
    end
  end

  // Update hold counts, stamps, order counter and latch bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        hold_r[i]  <= '0;
        stamp_r[i] <= '0;
      end
      order_r   <= '0;
      latched_r <= 1'b0;
    end else if (ctl.exec) begin
      latched_r <= latched_nxt;
      if (clr_all) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          hold_r[i] <= '0;
        end
      end
      if (hold_we) hold_r[addr] <= hold_wd;
      if (stamp_we) begin
        stamp_r[addr] <= order_nxt;
        order_r       <= order_nxt;
      end
    end
  end

  // Clear and step the select scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
    end else if (ctl.exec) begin
      sc_r <= '0;
    end else if (ctl.scan_step) begin
      sc_r <= sc_r + 4'd1;
    end
  end

  // Track the best candidate so far
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      best_r       <= '0;
      best_stamp_r <= '0;
    end else if (ctl.scan_step && hit) begin
      best_r       <= sc_r[IW-1:0];
      best_stamp_r <= stamp_rd;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (ctl.load_res) result_r <= result_nxt;
  end

  assign out_current_state = result_r;

endmodule

// ----- src/control_state_tracker.sv -----
// Top level of the control state tracker: controller plus datapath.
//
// Tracks one emulated control (momentary, latch or multi-state select).
// Input: raise start with in_cmd, in_state_index and in_latch_on while
// busy is low; the word is taken at that edge. Result: out_valid pulses for
// one cycle with out_current_state, the control's state after the command.
// The receiver cannot hold results off; each word yields exactly one result.
// Order: the word is captured, then executed, then a select control scans
// its states, clamped to MAX_STATES, and the result is registered for the
// strobe; busy stays high until the strobe ends, so the next word is taken
// at the end of the cycle after at the earliest. The scan compares one
// state per cycle through a single read port on the hold and stamp arrays.
// Configuration: cfg_index 0 is the control kind, 1 the state count; the
// port is always ready and must be written only while the block is idle.
// Reset (rst_n low, synchronous) clears all hold counts, stamps, the order
// counter and latch bit, and sets kind momentary with two states.
module control_state_tracker import cst_pkg::*; #(
  parameter int MAX_STATES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_cmd,
  input  logic signed [3:0] in_state_index,
  input  logic              in_latch_on,
  output logic              out_valid,
  output logic [2:0]        out_current_state,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data
);

  cst_cmd_t ctl;
  cst_sts_t sts;

  assign cfg_ready = 1'b1;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cst_dp #(
    .MAX_STATES (MAX_STATES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_state_index    (in_state_index),
    .in_latch_on       (in_latch_on),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ctl               (ctl),
    .sts               (sts),
    .out_current_state (out_current_state)
  );

endmodule

// ----- test/tb_control_state_tracker.sv -----
// Self-checking testbench for the control state tracker block.
module tb_control_state_tracker import cst_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Command and kind codes that the package leaves unnamed
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  // Negative state indexes, all read as state 1
  localparam logic [3:0] IDX_MINUS_1 = 4'hF;
  localparam logic [3:0] IDX_MINUS_8 = 4'h8;

  localparam int STATE_SLOTS   = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_WORDS   = 86;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_cmd;
  logic signed [3:0] in_state_index;
  logic              in_latch_on;
  logic              out_valid;
  logic [2:0]        out_current_state;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [3:0]        cfg_data;

  // Shadow of the tracker state and its registers
  logic [7:0]  hold_cnt_m [STATE_SLOTS];
  logic [31:0] stamp_m [STATE_SLOTS];
  logic [31:0] order_cnt_m;
  logic        latch_m;
  logic [1:0]  kind_m;
  logic [3:0]  nstates_m;

  // Resolved states still owed by the block, oldest first
  logic [2:0] pending_state_q [$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;

  control_state_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_state_index    (in_state_index),
    .in_latch_on       (in_latch_on),
    .out_valid         (out_valid),
    .out_current_state (out_current_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Apply one command word to the shadow state and return the resolved state
  function automatic logic [2:0] resolve_after(input logic [2:0] cmd,
                                               input logic [3:0] idx,
                                               input logic lon);
    int          live;
    int          sel;
    logic [31:0] top_stamp;
    logic [2:0]  res;
    live = (nstates_m > STATE_SLOTS) ? STATE_SLOTS : int'(nstates_m);
    sel = idx[3] ? 1 : int'(idx[2:0]);
    if (sel >= live) sel = -1;
    case (cmd)
      CMD_PRESS: begin
        if (kind_m == KIND_LATCH) begin
          latch_m = ~latch_m;
        end else if (sel >= 0) begin
          if (hold_cnt_m[sel] != HOLD_MAX) hold_cnt_m[sel] = hold_cnt_m[sel] + 8'd1;
          order_cnt_m = order_cnt_m + 32'd1;
          stamp_m[sel] = order_cnt_m;
        end
      end
      CMD_RELEASE: begin
        if (kind_m != KIND_LATCH && sel >= 0 && hold_cnt_m[sel] != 8'd0)
          hold_cnt_m[sel] = hold_cnt_m[sel] - 8'd1;
      end
      CMD_SET_LATCH: begin
        if (kind_m == KIND_LATCH) latch_m = lon;
      end
      CMD_RELEASE_ALL: begin
        foreach (hold_cnt_m[s]) hold_cnt_m[s] = 8'd0;
      end
      default: ;
    endcase
    // Latch and momentary read one bit; select picks the newest held state
    res = 3'd0;
    top_stamp = 32'd0;
    if (kind_m == KIND_LATCH) begin
      res = {2'b00, latch_m};
    end else if (kind_m == KIND_MOMENTARY) begin
      res = {2'b00, hold_cnt_m[1] != 8'd0};
    end else begin
      for (int s = 0; s < live; s++) begin
        if (hold_cnt_m[s] != 8'd0 && stamp_m[s] >= top_stamp) begin
          res = s[2:0];
          top_stamp = stamp_m[s];
        end
      end
    end
    return res;
  endfunction

  // Send one word after a gap; return at the edge that takes it
  task automatic send_word(input logic [2:0] cmd, input logic [3:0] idx,
                           input logic lon, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_state_index <= idx;
    in_latch_on    <= lon;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_state_q.push_back(resolve_after(cmd, idx, lon));
  endtask

  // Drain the block, then write kind and state count back to back
  task automatic set_config(input logic [1:0] kind, input logic [3:0] nstates,
                            input logic [1:0] pad);
    start <= 1'b0;
    while (pending_state_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_KIND;
    cfg_data  <= {pad, kind};
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    kind_m = kind;
    cfg_index <= CFG_NUM_STATES;
    cfg_data  <= nstates;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    nstates_m = nstates;
    cfg_valid <= 1'b0;
  endtask

  // Check each result word against the oldest expectation
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_state_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", out_current_state));
      end else if (out_current_state !== pending_state_q[0]) begin
        report_mismatch($sformatf("current_state got %0d want %0d",
                                  out_current_state, pending_state_q[0]));
        void'(pending_state_q.pop_front());
      end else begin
        void'(pending_state_q.pop_front());
      end
    end
  end

  function automatic int draw_gap();
    return $urandom_range(0, 12);
  endfunction

  // Momentary at reset settings: state 1 drives the output
  task automatic test_momentary_defaults();
    send_word(CMD_QUERY, 4'd0, 1'b0, draw_gap());
    send_word(CMD_PRESS, 4'd1, 1'b0, draw_gap());
    send_word(CMD_PRESS, IDX_MINUS_1, 1'b0, draw_gap());
    send_word(CMD_RELEASE, 4'd1, 1'b0, draw_gap());
    send_word(CMD_RELEASE, IDX_MINUS_8, 1'b1, draw_gap());
    send_word(CMD_RELEASE, 4'd1, 1'b0, draw_gap());
    send_word(CMD_PRESS, 4'd7, 1'b0, draw_gap());
    send_word(CMD_SET_LATCH, 4'd0, 1'b1, draw_gap());
    send_word(CMD_PRESS, 4'd1, 1'b0, draw_gap());
    send_word(CMD_SPARE_7, 4'd1, 1'b1, draw_gap());
    send_word(CMD_RELEASE_ALL, 4'd0, 1'b0, draw_gap());
  endtask

  // Latch: toggle, set, and commands that must leave the bit alone
  task automatic test_latch();
    set_config(KIND_LATCH, 4'd2, 2'b00);
    send_word(CMD_PRESS, 4'd0, 1'b0, draw_gap());
    send_word(CMD_RELEASE, 4'd1, 1'b0, draw_gap());
    send_word(CMD_RELEASE_ALL, 4'd0, 1'b0, draw_gap());
    send_word(CMD_PRESS, 4'd7, 1'b0, draw_gap());
    send_word(CMD_SET_LATCH, 4'd0, 1'b1, draw_gap());
    send_word(CMD_SET_LATCH, 4'd0, 1'b0, draw_gap());
  endtask

  // Select: newest held state wins, release falls back to older presses
  task automatic test_select();
    set_config(KIND_SELECT, 4'd8, 2'b00);
    send_word(CMD_PRESS, 4'd0, 1'b0, draw_gap());
    send_word(CMD_PRESS, 4'd7, 1'b0, draw_gap());
    send_word(CMD_PRESS, 4'd3, 1'b0, draw_gap());
    send_word(CMD_RELEASE, 4'd3, 1'b0, draw_gap());
    send_word(CMD_SPARE_5, 4'd3, 1'b0, draw_gap());
    send_word(CMD_SPARE_6, 4'd0, 1'b1, draw_gap());
  endtask

  // Odd state counts and the reserved kind code
  task automatic test_state_count_edges();
    set_config(KIND_RSVD, 4'd15, 2'b11);
    send_word(CMD_PRESS, 4'd5, 1'b0, draw_gap());
    set_config(KIND_SELECT, 4'd1, 2'b00);
    send_word(CMD_PRESS, 4'd1, 1'b0, draw_gap());
    set_config(KIND_MOMENTARY, 4'd0, 2'b00);
    send_word(CMD_PRESS, 4'd0, 1'b0, draw_gap());
    send_word(CMD_QUERY, 4'd0, 1'b0, draw_gap());
  endtask

  // Hold count saturates at its limit, then releases count it down to zero
  task automatic test_hold_saturation();
    set_config(KIND_SELECT, 4'd2, 2'b00);
    send_word(CMD_RELEASE_ALL, 4'd0, 1'b0, 0);
    repeat (260) send_word(CMD_PRESS, 4'd1, 1'b0, $urandom_range(0, 1));
    repeat (256) send_word(CMD_RELEASE, 4'd1, 1'b0, $urandom_range(0, 1));
  endtask

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return CMD_PRESS;
    if (r < 68) return CMD_RELEASE;
    if (r < 76) return CMD_SET_LATCH;
    if (r < 80) return CMD_RELEASE_ALL;
    if (r < 90) return CMD_QUERY;
    case ($urandom_range(0, 2))
      0: return CMD_SPARE_5;
      1: return CMD_SPARE_6;
      default: return CMD_SPARE_7;
    endcase
  endfunction

  // Mostly live states, some negative and some anywhere in the field
  function automatic logic [3:0] pick_index();
    int r;
    int hi;
    r = $urandom_range(0, 99);
    hi = (nstates_m > STATE_SLOTS) ? STATE_SLOTS - 1 : int'(nstates_m) - 1;
    if (hi < 1) hi = 1;
    if (r < 12) return 4'($urandom);
    if (r < 22) return {1'b1, 3'($urandom)};
    return 4'($urandom_range(0, hi));
  endfunction

  // Random command traffic across a sweep of settings
  task automatic test_random_traffic();
    logic [1:0] kind;
    logic [3:0] nstates;
    bit         burst;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin kind = KIND_SELECT;    nstates = 4'd8;  end
        1: begin kind = KIND_MOMENTARY; nstates = 4'd2;  end
        2: begin kind = KIND_LATCH;     nstates = 4'd2;  end
        3: begin kind = KIND_RSVD;      nstates = 4'd15; end
        4: begin kind = KIND_SELECT;    nstates = 4'd1;  end
        5: begin kind = KIND_SELECT;    nstates = 4'd0;  end
        6: begin kind = KIND_MOMENTARY; nstates = 4'd8;  end
        default: begin
          kind = 2'($urandom_range(0, 3));
          nstates = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(2, 8));
        end
      endcase
      set_config(kind, nstates, 2'($urandom));
      // Some phases run back to back with no gaps at all
      burst = (p % 3 == 2) || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(pick_cmd(), pick_index(), 1'($urandom), burst ? 0 : draw_gap());
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_cmd         <= CMD_QUERY;
    in_state_index <= 4'd0;
    in_latch_on    <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_KIND;
    cfg_data       <= 4'd0;
    foreach (hold_cnt_m[s]) begin
      hold_cnt_m[s] = 8'd0;
      stamp_m[s]    = 32'd0;
    end
    order_cnt_m = 32'd0;
    latch_m     = 1'b0;
    kind_m      = KIND_RESET;
    nstates_m   = NUM_STATES_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_momentary_defaults();
    test_latch();
    test_select();
    test_state_count_edges();
    test_hold_saturation();
    test_random_traffic();

    // Drain, then give a late or extra word time to show up
    start <= 1'b0;
    while (pending_state_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
